// ----- hdl/ibpf_pkg.sv -----
`default_nettype none

package ibpf_pkg;

  // width of the position field of a result
  localparam int unsigned POS_W = 6;

  // two-entry queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // classification of one request, made by the front
  typedef struct packed {
    logic store;    // candidate gets a store entry
    logic set_end;  // candidate closes the set
    logic ovf;      // some candidate of this set found the store full
  } ibpf_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_ROW,
    S_CMP,
    S_EMIT,
    S_FLUSH
  } ibpf_state_e;

endpackage

`default_nettype wire

// ----- hdl/interval_bound_pareto_filter.sv -----
`default_nettype none

// channel | handshake                   | payload
// --------+-----------------------------+-----------------------------------------------
// in      | in_valid_i / in_stall_o     | lower_cost_one/two_i, upper_cost_one/two_i,
//         |                             | set_end_i
// out     | out_valid_o / out_stall_i   | position_o, kept_lower_one/two_o,
//         |                             | kept_upper_one/two_o, final_item_o, none_kept_o,
//         |                             | overflowed_o
//
// a candidate without set_end is taken while the filter is idle
// a kept row is compared with every later row read from the store, a dropped row is skipped
// rst_ni clears the queue and counters and sets every keep mark at once; the store needs no clearing
// requests queue up (two deep) in front of a running filter, then in_stall_o rises
// out_stall_i holds the output register and pauses the run at the next survivor

module interval_bound_pareto_filter import ibpf_pkg::*; #(
  parameter int unsigned SET_DEPTH = 64,
  parameter int unsigned COST_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [COST_BITS-1:0] lower_cost_one_i,
  input  wire logic [COST_BITS-1:0] lower_cost_two_i,
  input  wire logic [COST_BITS-1:0] upper_cost_one_i,
  input  wire logic [COST_BITS-1:0] upper_cost_two_i,
  input  wire logic                 set_end_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [POS_W-1:0]          position_o,
  output logic [COST_BITS-1:0]      kept_lower_one_o,
  output logic [COST_BITS-1:0]      kept_lower_two_o,
  output logic [COST_BITS-1:0]      kept_upper_one_o,
  output logic [COST_BITS-1:0]      kept_upper_two_o,
  output logic                      final_item_o,
  output logic                      none_kept_o,
  output logic                      overflowed_o
);

  localparam int unsigned ROW_W = 4 * COST_BITS;
  localparam int unsigned ENT_W = ROW_W + $bits(ibpf_ctrl_t);

  logic             q_full, q_empty, q_push, q_pop;
  ibpf_ctrl_t       f_ctrl, b_ctrl;
  logic [ROW_W-1:0] f_data, b_data;
  logic [ENT_W-1:0] q_out;

  ibpf_front #(
    .SET_DEPTH (SET_DEPTH),
    .COST_BITS (COST_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .lower_cost_one_i (lower_cost_one_i),
    .lower_cost_two_i (lower_cost_two_i),
    .upper_cost_one_i (upper_cost_one_i),
    .upper_cost_two_i (upper_cost_two_i),
    .set_end_i        (set_end_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_ctrl_o         (f_ctrl),
    .q_data_o         (f_data)
  );

  ibpf_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({f_ctrl, f_data}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  assign {b_ctrl, b_data} = q_out;

  ibpf_back #(
    .SET_DEPTH (SET_DEPTH),
    .COST_BITS (COST_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_ctrl_i         (b_ctrl),
    .q_data_i         (b_data),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .position_o       (position_o),
    .kept_lower_one_o (kept_lower_one_o),
    .kept_lower_two_o (kept_lower_two_o),
    .kept_upper_one_o (kept_upper_one_o),
    .kept_upper_two_o (kept_upper_two_o),
    .final_item_o     (final_item_o),
    .none_kept_o      (none_kept_o),
    .overflowed_o     (overflowed_o)
  );

endmodule

`default_nettype wire

// ----- hdl/ibpf_front.sv -----
`default_nettype none

module ibpf_front import ibpf_pkg::*; #(
  parameter int unsigned SET_DEPTH = 64,
  parameter int unsigned COST_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [COST_BITS-1:0]   lower_cost_one_i,
  input  wire logic [COST_BITS-1:0]   lower_cost_two_i,
  input  wire logic [COST_BITS-1:0]   upper_cost_one_i,
  input  wire logic [COST_BITS-1:0]   upper_cost_two_i,
  input  wire logic                   set_end_i,
  input  wire logic                   q_full_i,
  output logic                        q_push_o,
  output ibpf_ctrl_t                  q_ctrl_o,
  output logic [4*COST_BITS-1:0]      q_data_o
);

  localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             accept;
  logic             has_room;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign has_room   = (cnt_q < CNT_W'(SET_DEPTH));

  assign q_push_o         = accept;
  assign q_ctrl_o.store   = has_room;
  assign q_ctrl_o.set_end = set_end_i;
  assign q_ctrl_o.ovf     = ovf_q || !has_room;
  assign q_data_o = {lower_cost_one_i, lower_cost_two_i, upper_cost_one_i, upper_cost_two_i};

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (set_end_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        if (has_room) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        ovf_d = ovf_q || !has_room;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ibpf_queue.sv -----
`default_nettype none

module ibpf_queue import ibpf_pkg::*; #(
  parameter int unsigned WIDTH = 131
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ibpf_back.sv -----
`default_nettype none

module ibpf_back import ibpf_pkg::*; #(
  parameter int unsigned SET_DEPTH = 64,
  parameter int unsigned COST_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_empty_i,
  input  wire ibpf_ctrl_t             q_ctrl_i,
  input  wire logic [4*COST_BITS-1:0] q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [POS_W-1:0]            position_o,
  output logic [COST_BITS-1:0]        kept_lower_one_o,
  output logic [COST_BITS-1:0]        kept_lower_two_o,
  output logic [COST_BITS-1:0]        kept_upper_one_o,
  output logic [COST_BITS-1:0]        kept_upper_two_o,
  output logic                        final_item_o,
  output logic                        none_kept_o,
  output logic                        overflowed_o
);

  localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);
  localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned ROW_W = 4 * COST_BITS;

  ibpf_state_e state_q, state_d;

  logic [ROW_W-1:0]     mem [SET_DEPTH];
  logic [ROW_W-1:0]     rd_q;
  logic [ROW_W-1:0]     row_q;
  logic                 mem_we, mem_re, row_ld;
  logic [IDX_W-1:0]     rd_addr;

  logic [CNT_W-1:0]     wr_q, wr_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     i_q, i_d;
  logic [CNT_W-1:0]     j_q, j_d;
  logic [IDX_W-1:0]     jd_q, jd_d;
  logic                 rdv_q, rdv_d;
  logic                 ovf_q, ovf_d;
  logic [SET_DEPTH-1:0] keep_q, keep_d;
  logic [IDX_W-1:0]     i_idx;

  logic                 pend_v_q, pend_v_d, pend_ld;
  logic [IDX_W-1:0]     pend_pos_q;
  logic [ROW_W-1:0]     pend_row_q;

  logic                 can_push, out_push;
  logic                 push_final, push_none;
  logic [POS_W-1:0]     push_pos;
  logic [ROW_W-1:0]     push_row;
  logic                 out_valid_q;
  logic [POS_W-1:0]     out_pos_q;
  logic [ROW_W-1:0]     out_row_q;
  logic                 out_final_q, out_none_q, out_ovf_q;

  logic [COST_BITS-1:0] r_lo1, r_lo2, r_up1, r_up2;
  logic [COST_BITS-1:0] d_lo1, d_lo2, d_up1, d_up2;
  logic                 i_beaten, j_beaten;

  assign i_idx    = i_q[IDX_W-1:0];
  assign can_push = !out_valid_q || !out_stall_i;

  assign {r_lo1, r_lo2, r_up1, r_up2} = row_q;
  assign {d_lo1, d_lo2, d_up1, d_up2} = rd_q;

  // row i against row j, both directions
  assign i_beaten = (r_lo1 >= d_up1) && (r_lo2 >= d_up2) && !((r_lo1 == d_up1) && (r_lo2 == d_up2));
  assign j_beaten = (d_lo1 >= r_up1) && (d_lo2 >= r_up2) && !((d_lo1 == r_up1) && (d_lo2 == r_up2));

  always_comb begin
    state_d    = state_q;
    wr_d       = wr_q;
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    jd_d       = jd_q;
    rdv_d      = 1'b0;
    ovf_d      = ovf_q;
    keep_d     = keep_q;
    pend_v_d   = pend_v_q;
    pend_ld    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    rd_addr    = i_idx;
    row_ld     = 1'b0;
    q_pop_o    = 1'b0;
    out_push   = 1'b0;
    push_pos   = POS_W'(pend_pos_q);
    push_row   = pend_row_q;
    push_final = 1'b0;
    push_none  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_ctrl_i.store) begin
            mem_we = 1'b1;
            wr_d   = wr_q + CNT_W'(1);
          end
          if (q_ctrl_i.set_end) begin
            n_d     = q_ctrl_i.store ? wr_q + CNT_W'(1) : wr_q;
            ovf_d   = q_ctrl_i.ovf;
            i_d     = '0;
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (i_q == n_q) begin
          state_d = S_FLUSH;
        end else if (keep_q[i_idx]) begin
          mem_re  = 1'b1;
          rd_addr = i_idx;
          j_d     = i_q + CNT_W'(1);
          state_d = S_ROW;
        end else begin
          i_d = i_q + CNT_W'(1);
        end
      end
      S_ROW, S_CMP: begin
        if (state_q == S_ROW) begin
          row_ld = 1'b1;
        end
        // stream rows j > i, compare in the cycle after the read
        if (j_q < n_q) begin
          mem_re  = 1'b1;
          rd_addr = j_q[IDX_W-1:0];
          jd_d    = j_q[IDX_W-1:0];
          rdv_d   = 1'b1;
          j_d     = j_q + CNT_W'(1);
        end
        if (state_q == S_ROW) begin
          state_d = S_CMP;
        end else begin
          if (rdv_q) begin
            if (i_beaten) begin
              keep_d[i_idx] = 1'b0;
            end
            if (j_beaten) begin
              keep_d[jd_q] = 1'b0;
            end
          end else if (j_q >= n_q) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (keep_q[i_idx]) begin
          // the held survivor is not the last one, send it on
          if (!pend_v_q || can_push) begin
            out_push = pend_v_q;
            pend_v_d = 1'b1;
            pend_ld  = 1'b1;
            i_d      = i_q + CNT_W'(1);
            state_d  = S_NEXT;
          end
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_NEXT;
        end
      end
      S_FLUSH: begin
        if (can_push) begin
          out_push   = 1'b1;
          push_final = 1'b1;
          if (!pend_v_q) begin
            push_none = 1'b1;
            push_pos  = '0;
            push_row  = '0;
          end
          keep_d   = '1;
          wr_d     = '0;
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_q[IDX_W-1:0]] <= q_data_i;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_ld) begin
      row_q <= rd_q;
    end
    if (pend_ld) begin
      pend_pos_q <= i_idx;
      pend_row_q <= row_q;
    end
    if (out_push) begin
      out_pos_q   <= push_pos;
      out_row_q   <= push_row;
      out_final_q <= push_final;
      out_none_q  <= push_none;
      out_ovf_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_q        <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      jd_q        <= '0;
      rdv_q       <= 1'b0;
      ovf_q       <= 1'b0;
      keep_q      <= '1;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_q     <= wr_d;
      n_q      <= n_d;
      i_q      <= i_d;
      j_q      <= j_d;
      jd_q     <= jd_d;
      rdv_q    <= rdv_d;
      ovf_q    <= ovf_d;
      keep_q   <= keep_d;
      pend_v_q <= pend_v_d;
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_o   = out_pos_q;
  assign {kept_lower_one_o, kept_lower_two_o, kept_upper_one_o, kept_upper_two_o} = out_row_q;
  assign final_item_o = out_final_q;
  assign none_kept_o  = out_none_q;
  assign overflowed_o = out_ovf_q;

  // a compared row always lies above row i and inside the set
  a_cmp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && rdv_q) |-> (CNT_W'(jd_q) > i_q) && (CNT_W'(jd_q) < n_q))
    else $error("compared row outside the range above row i");

  // no survivor is held between runs
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("survivor held while idle");

  // the end of a run leaves every keep mark set and the fill count at zero
  a_keep_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && can_push) |=> (&keep_q) && (wr_q == '0))
    else $error("keep marks or fill count not cleared after a run");

endmodule

`default_nettype wire
